FILE: src/esmc_pkg.sv
// Shared types and constants for the ESC speed mode controller.
// No dependencies; used by esmc_step and esc_speed_mode_controller.
package esmc_pkg;

    localparam logic [2:0] MODE_ARM  = 3'd0;
    localparam logic [2:0] MODE_WAIT = 3'd1;
    localparam logic [2:0] MODE_STOP = 3'd2;
    localparam logic [2:0] MODE_FWD  = 3'd3;
    localparam logic [2:0] MODE_REV0 = 3'd4;
    localparam logic [2:0] MODE_REV1 = 3'd5;
    localparam logic [2:0] MODE_REV  = 3'd6;

    localparam logic KIND_CMD  = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    localparam logic [2:0] CFG_ARM_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_NEUTRAL     = 3'd1;
    localparam logic [2:0] CFG_FWD_START   = 3'd2;
    localparam logic [2:0] CFG_REV_START   = 3'd3;
    localparam logic [2:0] CFG_MAX_DUTY    = 3'd4;
    localparam logic [2:0] CFG_MIN_DUTY    = 3'd5;
    localparam logic [2:0] CFG_FWD_STEP    = 3'd6;
    localparam logic [2:0] CFG_REV_STEP    = 3'd7;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [15:0] RST_ARM_TIMEOUT = 16'd3000;
    localparam logic [11:0] RST_NEUTRAL     = 12'd1780;
    localparam logic [11:0] RST_FWD_START   = 12'd1880;
    localparam logic [11:0] RST_REV_START   = 12'd1640;
    localparam logic [11:0] RST_MAX_DUTY    = 12'd2000;
    localparam logic [11:0] RST_MIN_DUTY    = 12'd1400;
    localparam logic [7:0]  RST_FWD_STEP    = 8'd1;
    localparam logic [7:0]  RST_REV_STEP    = 8'd2;

    localparam logic [10:0] SPEED_CMD_MAX  = 11'd1000;
    localparam logic [9:0]  STEER_CMD_MAX  = 10'd400;
    localparam logic [11:0] STEER_DUTY_TOP = 12'd2310;
    localparam logic signed [10:0] FWD_THRESH = 11'sd15;
    localparam logic signed [10:0] REV_THRESH = -11'sd15;

    typedef struct packed {
        logic        kind;
        logic [10:0] speed_cmd;
        logic [9:0]  steer_cmd;
        logic [31:0] now_ms;
        logic [13:0] ground_speed;
    } t_in_item;

    typedef struct packed {
        logic [11:0] speed_duty;
        logic [11:0] steer_duty;
        logic [2:0]  mode;
        logic        cmd_accepted;
    } t_out_item;

    typedef struct packed {
        logic [15:0] arm_timeout_ms;
        logic [11:0] neutral_duty;
        logic [11:0] forward_start_duty;
        logic [11:0] reverse_start_duty;
        logic [11:0] max_duty;
        logic [11:0] min_duty;
        logic [7:0]  forward_step;
        logic [7:0]  reverse_step;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         mode;
        logic [11:0]        duty;
        logic [11:0]        pwm;
        logic [31:0]        arm_start_ms;
        logic [2:0]         stop_count;
        logic [1:0]         reverse_count;
        logic signed [10:0] requested_speed;
        logic [11:0]        steer_duty;
    } t_state;

    // 2310 - floor((steer*101 + 20) / 40); /40 done as >>3 then /5 by reciprocal
    function automatic logic [11:0] steer_map(input logic [9:0] steer);
        logic [15:0] x;
        logic [12:0] y;
        logic [28:0] prod;
        x = ({6'd0, steer} << 6) + ({6'd0, steer} << 5) + ({6'd0, steer} << 2)
            + {6'd0, steer} + 16'd20;
        y = x[15:3];
        prod = {16'd0, y} * 29'd52429;
        return STEER_DUTY_TOP - {1'b0, prod[28:18]};
    endfunction

endpackage

FILE: src/esmc_step.sv
// Next-state logic for one item: command range check and speed mode sequencer.
// Depends on esmc_pkg.
module esmc_step (
    input  esmc_pkg::t_state   i_state,
    input  esmc_pkg::t_cfg     i_cfg,
    input  esmc_pkg::t_in_item i_item,
    output esmc_pkg::t_state   o_state,
    output logic               o_cmd_accepted
);

    logic signed [15:0] req_w;
    logic signed [15:0] gnd_w;
    logic signed [15:0] neg_gnd_w;
    logic [31:0]        elapsed;
    logic               req_above_fwd;
    logic               req_below_fwd;
    logic               req_below_rev;
    logic               req_above_rev;
    logic [12:0]        fwd_up;
    logic [12:0]        fwd_floor;
    logic [12:0]        rev_up;
    logic signed [13:0] rev_dn;
    logic [11:0]        fwd_d;
    logic [11:0]        rev_d;
    esmc_pkg::t_state   n;

    assign req_w     = 16'(i_state.requested_speed);
    assign gnd_w     = $signed({2'b00, i_item.ground_speed});
    assign neg_gnd_w = -gnd_w;
    assign elapsed   = i_item.now_ms - i_state.arm_start_ms;

    assign req_above_fwd = i_state.requested_speed > esmc_pkg::FWD_THRESH;
    assign req_below_fwd = i_state.requested_speed < esmc_pkg::FWD_THRESH;
    assign req_below_rev = i_state.requested_speed < esmc_pkg::REV_THRESH;
    assign req_above_rev = i_state.requested_speed > esmc_pkg::REV_THRESH;

    // forward ramp: step only while the result stays inside [start, max]
    assign fwd_up    = {1'b0, i_state.duty} + {5'd0, i_cfg.forward_step};
    assign fwd_floor = {1'b0, i_cfg.forward_start_duty} + {5'd0, i_cfg.forward_step};

    always_comb begin
        fwd_d = i_state.duty;
        if (gnd_w < req_w) begin
            if (fwd_up <= {1'b0, i_cfg.max_duty}) begin
                fwd_d = fwd_up[11:0];
            end
        end else if (gnd_w > req_w) begin
            if ({1'b0, i_state.duty} >= fwd_floor) begin
                fwd_d = i_state.duty - {4'd0, i_cfg.forward_step};
            end
        end
    end

    // reverse ramp saturates at max / min
    assign rev_up = {1'b0, i_state.duty} + {5'd0, i_cfg.reverse_step};
    assign rev_dn = $signed({2'b00, i_state.duty}) - $signed({6'd0, i_cfg.reverse_step});

    always_comb begin
        rev_d = i_state.duty;
        if (neg_gnd_w < req_w) begin
            rev_d = (rev_up > {1'b0, i_cfg.max_duty}) ? i_cfg.max_duty : rev_up[11:0];
        end else if (neg_gnd_w > req_w) begin
            rev_d = (rev_dn < $signed({2'b00, i_cfg.min_duty})) ? i_cfg.min_duty
                                                                 : rev_dn[11:0];
        end
    end

    always_comb begin
        n = i_state;
        o_cmd_accepted = 1'b0;
        if (i_item.kind == esmc_pkg::KIND_CMD) begin
            if (i_item.speed_cmd <= esmc_pkg::SPEED_CMD_MAX &&
                i_item.steer_cmd <= esmc_pkg::STEER_CMD_MAX) begin
                o_cmd_accepted = 1'b1;
                n.requested_speed = $signed({i_item.speed_cmd[9:0], 1'b0})
                                    - 11'sd1000;
                n.steer_duty = esmc_pkg::steer_map(i_item.steer_cmd);
            end
        end else begin
            case (i_state.mode)
                esmc_pkg::MODE_WAIT: begin
                    if (elapsed >= {16'd0, i_cfg.arm_timeout_ms}) begin
                        n.mode = esmc_pkg::MODE_STOP;
                    end
                end
                esmc_pkg::MODE_STOP: begin
                    n.pwm = i_cfg.neutral_duty;
                    if (req_above_fwd) begin
                        n.mode       = esmc_pkg::MODE_FWD;
                        n.duty       = i_cfg.forward_start_duty;
                        n.stop_count = 3'd0;
                    end else if (req_below_rev) begin
                        n.mode          = esmc_pkg::MODE_REV0;
                        n.reverse_count = 2'd0;
                        n.stop_count    = 3'd0;
                        n.duty          = i_cfg.reverse_start_duty;
                        n.pwm           = i_cfg.reverse_start_duty;
                    end
                end
                esmc_pkg::MODE_FWD: begin
                    if (req_below_fwd && i_state.stop_count > 3'd3) begin
                        // fifth low request in a row
                        n.stop_count = 3'd0;
                        n.duty       = i_cfg.neutral_duty;
                        n.pwm        = i_cfg.neutral_duty;
                        n.mode       = esmc_pkg::MODE_STOP;
                    end else begin
                        n.stop_count = req_below_fwd ? i_state.stop_count + 3'd1 : 3'd0;
                        n.duty       = fwd_d;
                        n.pwm        = fwd_d;
                    end
                end
                esmc_pkg::MODE_REV0: begin
                    n.stop_count = 3'd0;
                    n.duty       = i_cfg.neutral_duty;
                    n.pwm        = i_cfg.neutral_duty;
                    if (i_state.reverse_count < 2'd2) begin
                        n.reverse_count = i_state.reverse_count + 2'd1;
                    end else begin
                        n.mode          = esmc_pkg::MODE_REV1;
                        n.reverse_count = 2'd0;
                    end
                end
                esmc_pkg::MODE_REV1: begin
                    n.duty = i_cfg.reverse_start_duty;
                    n.pwm  = i_cfg.reverse_start_duty;
                    if (i_state.reverse_count < 2'd2) begin
                        n.reverse_count = i_state.reverse_count + 2'd1;
                    end else begin
                        n.mode          = esmc_pkg::MODE_REV;
                        n.reverse_count = 2'd0;
                    end
                end
                esmc_pkg::MODE_REV: begin
                    if (req_above_rev && i_state.stop_count >= 3'd3) begin
                        // stop count is left as is on exit
                        n.duty = i_cfg.neutral_duty;
                        n.pwm  = i_cfg.neutral_duty;
                        n.mode = esmc_pkg::MODE_STOP;
                    end else begin
                        if (req_above_rev) begin
                            n.stop_count = i_state.stop_count + 3'd1;
                        end
                        n.duty = rev_d;
                        n.pwm  = rev_d;
                    end
                end
                default: begin
                    // arm, and the unused code
                    n.duty         = i_cfg.neutral_duty;
                    n.pwm          = i_cfg.neutral_duty;
                    n.arm_start_ms = i_item.now_ms;
                    n.mode         = esmc_pkg::MODE_WAIT;
                end
            endcase
        end
    end

    assign o_state = n;

endmodule

FILE: src/esc_speed_mode_controller.sv
// ESC speed mode controller, top level; depends on esmc_pkg and esmc_step.
// Results are registered in the output register, or in the skid register when
// it is stalled. Throughput: one request per cycle while the skid register is
// empty; this two-entry buffer keeps input flowing while one result waits.
// Reset (synchronous, i_rst_n low): mode arm, all state zero, config registers
// to their defaults, output buffer empty.
module esc_speed_mode_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  esmc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output esmc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [esmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [esmc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    esmc_pkg::t_cfg      r_cfg;
    esmc_pkg::t_state    r_state;
    esmc_pkg::t_state    n_state;
    logic                step_acc;
    esmc_pkg::t_out_item step_result;

    logic                r_out_valid;
    logic                n_out_valid;
    esmc_pkg::t_out_item r_out;
    esmc_pkg::t_out_item n_out;
    logic                r_skid_valid;
    logic                n_skid_valid;
    esmc_pkg::t_out_item r_skid;
    esmc_pkg::t_out_item n_skid;

    logic in_take;
    logic out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_timeout_ms     <= esmc_pkg::RST_ARM_TIMEOUT;
            r_cfg.neutral_duty       <= esmc_pkg::RST_NEUTRAL;
            r_cfg.forward_start_duty <= esmc_pkg::RST_FWD_START;
            r_cfg.reverse_start_duty <= esmc_pkg::RST_REV_START;
            r_cfg.max_duty           <= esmc_pkg::RST_MAX_DUTY;
            r_cfg.min_duty           <= esmc_pkg::RST_MIN_DUTY;
            r_cfg.forward_step       <= esmc_pkg::RST_FWD_STEP;
            r_cfg.reverse_step       <= esmc_pkg::RST_REV_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                esmc_pkg::CFG_ARM_TIMEOUT: r_cfg.arm_timeout_ms     <= i_cfg_data;
                esmc_pkg::CFG_NEUTRAL:     r_cfg.neutral_duty       <= i_cfg_data[11:0];
                esmc_pkg::CFG_FWD_START:   r_cfg.forward_start_duty <= i_cfg_data[11:0];
                esmc_pkg::CFG_REV_START:   r_cfg.reverse_start_duty <= i_cfg_data[11:0];
                esmc_pkg::CFG_MAX_DUTY:    r_cfg.max_duty           <= i_cfg_data[11:0];
                esmc_pkg::CFG_MIN_DUTY:    r_cfg.min_duty           <= i_cfg_data[11:0];
                esmc_pkg::CFG_FWD_STEP:    r_cfg.forward_step       <= i_cfg_data[7:0];
                esmc_pkg::CFG_REV_STEP:    r_cfg.reverse_step       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    esmc_step u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_item         (i_in_item),
        .o_state        (n_state),
        .o_cmd_accepted (step_acc)
    );

    assign step_result.speed_duty   = n_state.pwm;
    assign step_result.steer_duty   = n_state.steer_duty;
    assign step_result.mode         = n_state.mode;
    assign step_result.cmd_accepted = step_acc;

    assign o_in_stall = r_skid_valid;
    assign in_take    = i_in_valid && !r_skid_valid;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = step_result;
                n_out_valid = in_take;
            end
        end else if (in_take) begin
            n_skid       = step_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
